// File: src/pcfsm_pkg.sv
// Shared constants, register indexes and helpers of the shadow map test block.
package pcfsm_pkg;

  // Default map size.
  localparam int unsigned MAP_WIDTH_DEF  = 256;
  localparam int unsigned MAP_HEIGHT_DEF = 256;

  // Field widths.
  localparam int unsigned POS_W    = 21;
  localparam int unsigned DEPTH_W  = 32;
  localparam int unsigned USED_W   = 9;
  localparam int unsigned BIAS_W   = 16;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned FACTOR_W = 9;
  localparam int unsigned COORD_W  = POS_W - 7;  // integer part of a Q.8 sum, with sign
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_BIAS = 2'd2;

  // Register reset values.
  localparam logic [USED_W-1:0] MAP_USED_RST = 9'd256;
  localparam logic [BIAS_W-1:0] BIAS_RST     = 16'd328;

  // Depth that the map holds after reset.
  localparam logic [DEPTH_W-1:0] DEPTH_FLOOR = 32'h8000_0000;

  // Truncate a Q.8 value toward zero.
  function automatic logic [COORD_W-1:0] trunc_q8(input logic signed [POS_W:0] s);
    logic [COORD_W-1:0] fl;
    fl = s[POS_W:8];
    if (s[POS_W] && (s[7:0] != 8'd0)) begin
      fl = fl + COORD_W'(1);
    end
    return fl;
  endfunction

endpackage

// File: src/pcfsm_div.sv
// Bit-serial divider for the shadow factor: floor(256 * num / den), num <= den.
module pcfsm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pcfsm_pkg::CNT_W-1:0]    num_i,
  input  logic [pcfsm_pkg::CNT_W-1:0]    den_i,
  output logic                          done_o,
  output logic [pcfsm_pkg::FACTOR_W-1:0] quot_o
);
  import pcfsm_pkg::*;

  localparam int unsigned STEP_W = $clog2(FACTOR_W);

  logic                busy_q;
  logic [STEP_W-1:0]   step_q;
  logic [CNT_W-1:0]    rem_q;
  logic [CNT_W-1:0]    den_q;
  logic [FACTOR_W-1:0] quot_q;
  logic                done_q;

  logic [CNT_W:0]      trial;
  logic                ge;
  logic [CNT_W:0]      diff;

  // First step tests the numerator itself, later steps the doubled remainder.
  assign trial = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(FACTOR_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quot_q <= {quot_q[FACTOR_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: src/pcf_shadow_map_test.sv
// Top level: shadow depth map and 4x4 percentage-closer shadow test.
// Write transaction: busy is high in the write state, then the next start is taken.
// Query: 16 map reads, a read drain, then the bit-serial divider; the result strobe
// is registered from the divider's done as the block returns to idle.
// After reset the store is swept to the most negative depth, one entry a cycle,
// with busy high until every entry is written. Results cannot be stalled.
module pcf_shadow_map_test #(
  parameter int unsigned MAP_WIDTH  = pcfsm_pkg::MAP_WIDTH_DEF,
  parameter int unsigned MAP_HEIGHT = pcfsm_pkg::MAP_HEIGHT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 mode_i,
  input  logic signed [pcfsm_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [pcfsm_pkg::POS_W-1:0]   pos_y_i,
  input  logic signed [pcfsm_pkg::DEPTH_W-1:0] depth_i,
  input  logic                                 cfg_we_i,
  input  logic [pcfsm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pcfsm_pkg::BIAS_W-1:0]         cfg_wdata_i,
  output logic                                 result_valid_o,
  output logic [pcfsm_pkg::CNT_W-1:0]          shadowed_count_o,
  output logic [pcfsm_pkg::CNT_W-1:0]          valid_count_o,
  output logic [pcfsm_pkg::FACTOR_W-1:0]       shadow_factor_o,
  output logic                                 no_samples_o
);
  import pcfsm_pkg::*;

  localparam int unsigned ENTRIES = MAP_WIDTH * MAP_HEIGHT;
  localparam int unsigned AW      = $clog2(ENTRIES);
  localparam int unsigned COL_W   = $clog2(MAP_WIDTH);
  localparam int unsigned ROW_W   = $clog2(MAP_HEIGHT);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WR    = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       clr_q;
  logic [3:0]          step_q;

  logic [USED_W-1:0]   wused_q;
  logic [USED_W-1:0]   hused_q;
  logic [BIAS_W-1:0]   bias_q;

  logic [POS_W-1:0]    px_q;
  logic [POS_W-1:0]    py_q;
  logic [DEPTH_W:0]    hold_q;   // stored depth for a write, depth plus bias for a query

  logic                s_vld_q;
  logic                s_ok_q;
  logic [COL_W-1:0]    s_col_q;
  logic [ROW_W-1:0]    s_row_q;
  logic                p_vld_q;
  logic                p_ok_q;

  logic [CNT_W-1:0]    cnt_s_q;
  logic [CNT_W-1:0]    cnt_v_q;

  logic                res_vld_q;
  logic [CNT_W-1:0]    res_s_q;
  logic [CNT_W-1:0]    res_v_q;
  logic [FACTOR_W-1:0] res_f_q;
  logic                res_n_q;

  logic [DEPTH_W-1:0]  mem_q [ENTRIES];
  logic [DEPTH_W-1:0]  rdata_q;
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [DEPTH_W-1:0]  mem_wdata;
  logic [AW-1:0]       smp_addr;

  logic                accept;
  logic [2:0]          off_x, off_y;
  logic [POS_W:0]      sum_x, sum_y;
  logic [COORD_W-1:0]  tx, ty;
  logic [COORD_W-1:0]  wlim, hlim;
  logic                x_ok, y_ok;
  logic                wr_ok;
  logic                drained;
  logic                div_done;
  logic [FACTOR_W-1:0] div_quot;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);

  // Sample coordinates for the current window step.
  assign off_x = {1'b0, step_q[3:2]} - 3'd2;
  assign off_y = {1'b0, step_q[1:0]} - 3'd2;
  assign sum_x = {px_q[POS_W-1], px_q} + {{(POS_W-10){off_x[2]}}, off_x, 8'h00};
  assign sum_y = {py_q[POS_W-1], py_q} + {{(POS_W-10){off_y[2]}}, off_y, 8'h00};
  assign tx    = trunc_q8(sum_x);
  assign ty    = trunc_q8(sum_y);

  assign wlim = (int'(wused_q) > MAP_WIDTH)  ? COORD_W'(MAP_WIDTH)  : COORD_W'(wused_q);
  assign hlim = (int'(hused_q) > MAP_HEIGHT) ? COORD_W'(MAP_HEIGHT) : COORD_W'(hused_q);
  // A negative coordinate reads as a large unsigned value and fails the bound.
  assign x_ok = tx < wlim;
  assign y_ok = ty < hlim;

  assign wr_ok = !pos_x_i[POS_W-1] && (pos_x_i[POS_W-2:0] < (POS_W-1)'(MAP_WIDTH))
              && !pos_y_i[POS_W-1] && (pos_y_i[POS_W-2:0] < (POS_W-1)'(MAP_HEIGHT));

  assign smp_addr = AW'(AW'(s_row_q) * AW'(MAP_WIDTH)) + AW'(s_col_q);
  assign drained  = !s_vld_q && !p_vld_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = smp_addr;
    mem_wdata = hold_q[DEPTH_W-1:0];
    if (state_q == ST_CLR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_q;
      mem_wdata = DEPTH_FLOOR;
    end else if (state_q == ST_WR) begin
      mem_we = s_ok_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR:   if (clr_q == AW'(ENTRIES - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (start_i) state_d = mode_i ? ST_RD : ST_WR;
      ST_WR:    state_d = ST_IDLE;
      ST_RD:    if (step_q == 4'hf) state_d = ST_DRAIN;
      ST_DRAIN: if (drained) state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_q     <= '0;
      step_q    <= '0;
      s_vld_q   <= 1'b0;
      p_vld_q   <= 1'b0;
      res_vld_q <= 1'b0;
      wused_q   <= MAP_USED_RST;
      hused_q   <= MAP_USED_RST;
      bias_q    <= BIAS_RST;
    end else begin
      state_q   <= state_d;
      res_vld_q <= (state_q == ST_DIV) && div_done;
      s_vld_q   <= (state_q == ST_RD);
      p_vld_q   <= s_vld_q;
      if (state_q == ST_CLR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (accept) begin
        step_q <= '0;
      end else if (state_q == ST_RD) begin
        step_q <= step_q + 4'd1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAP_WIDTH:  wused_q <= cfg_wdata_i[USED_W-1:0];
          REG_MAP_HEIGHT: hused_q <= cfg_wdata_i[USED_W-1:0];
          REG_DEPTH_BIAS: bias_q  <= cfg_wdata_i;
          default:        ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    p_ok_q <= s_ok_q;
    if (accept) begin
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      cnt_s_q <= '0;
      cnt_v_q <= '0;
      if (mode_i) begin
        hold_q <= {depth_i[DEPTH_W-1], depth_i} + {{(DEPTH_W+1-BIAS_W){1'b0}}, bias_q};
      end else begin
        hold_q  <= {depth_i[DEPTH_W-1], depth_i};
        s_col_q <= pos_x_i[COL_W-1:0];
        s_row_q <= pos_y_i[ROW_W-1:0];
        s_ok_q  <= wr_ok;
      end
    end else if (state_q == ST_RD) begin
      s_col_q <= tx[COL_W-1:0];
      s_row_q <= ty[ROW_W-1:0];
      s_ok_q  <= x_ok && y_ok;
    end
    // Count the sample whose stored depth just came back.
    if (p_vld_q && p_ok_q) begin
      cnt_v_q <= cnt_v_q + CNT_W'(1);
      if ($signed(hold_q) < $signed({rdata_q[DEPTH_W-1], rdata_q})) begin
        cnt_s_q <= cnt_s_q + CNT_W'(1);
      end
    end
    if ((state_q == ST_DIV) && div_done) begin
      res_s_q <= cnt_s_q;
      res_v_q <= cnt_v_q;
      res_n_q <= (cnt_v_q == '0);
      res_f_q <= (cnt_v_q == '0) ? '0 : div_quot;
    end
  end

  pcfsm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == ST_DRAIN) && drained),
    .num_i   (cnt_s_q),
    .den_i   (cnt_v_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign result_valid_o   = res_vld_q;
  assign shadowed_count_o = res_s_q;
  assign valid_count_o    = res_v_q;
  assign shadow_factor_o  = res_f_q;
  assign no_samples_o     = res_n_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |=> !res_vld_q)
    else $error("result strobe held longer than one cycle");

  a_counts_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (shadowed_count_o <= valid_count_o) && (valid_count_o <= CNT_W'(16)))
    else $error("shadowed count exceeds valid count");

  a_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && no_samples_o |-> (shadow_factor_o == '0) && (shadowed_count_o == '0))
    else $error("empty window with nonzero factor");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted transaction did not raise busy");

endmodule

// File: dv/tb_pcf_shadow_map_test.sv
// Self-checking testbench of the shadow map test block: directed table, then random phases.
module tb_pcf_shadow_map_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pcfsm_pkg::*;

  localparam longint MAP_W          = MAP_WIDTH_DEF;
  localparam longint MAP_H          = MAP_HEIGHT_DEF;
  localparam int     MAP_ENTRIES    = MAP_WIDTH_DEF * MAP_HEIGHT_DEF;
  localparam int     POS_MIN        = -1048576;
  localparam int     POS_MAX        = 1048575;
  localparam int     SETTLE_CYCLES  = 40;
  localparam int     WATCHDOG_LIMIT = 200000;
  localparam int     PHASES         = 6;
  localparam int     PHASE_ITEMS    = 138;
  localparam int     DIR_ROWS       = 34;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [DEPTH_W-1:0]   DEPTH_MAX  = 32'h7FFF_FFFF;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } pcf_mode_e;

  typedef struct packed {
    pcf_mode_e          mode;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [DEPTH_W-1:0] depth;
  } pcf_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]    shadowed;
    logic [CNT_W-1:0]    valid;
    logic [FACTOR_W-1:0] factor;
    logic                no_samples;
  } pcf_result_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [BIAS_W-1:0]    data;
    pcf_item_t            item;
    logic                 typed;
    pcf_result_t          want;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic                mode_i = 1'b0;
  logic [POS_W-1:0]    pos_x_i = '0;
  logic [POS_W-1:0]    pos_y_i = '0;
  logic [DEPTH_W-1:0]  depth_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [BIAS_W-1:0]   cfg_wdata_i = '0;
  logic                result_valid_o;
  logic [CNT_W-1:0]    shadowed_count_o;
  logic [CNT_W-1:0]    valid_count_o;
  logic [FACTOR_W-1:0] shadow_factor_o;
  logic                no_samples_o;

  pcf_shadow_map_test uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .mode_i           (mode_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .depth_i          (depth_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .result_valid_o   (result_valid_o),
    .shadowed_count_o (shadowed_count_o),
    .valid_count_o    (valid_count_o),
    .shadow_factor_o  (shadow_factor_o),
    .no_samples_o     (no_samples_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: map contents and register copies.
  logic [DEPTH_W-1:0] depth_map [MAP_ENTRIES];
  logic [USED_W-1:0]  width_used;
  logic [USED_W-1:0]  height_used;
  logic [BIAS_W-1:0]  bias_used;

  pcf_result_t shade_expect_q [$];
  dir_row_t    dir_rows [DIR_ROWS];

  int mismatches       = 0;
  int results_checked  = 0;
  int empty_windows    = 0;
  int full_shadow      = 0;
  int queries_sent     = 0;
  int writes_sent      = 0;
  int settings_applied = 0;
  int idle_cycles      = 0;

  function automatic longint q8_trunc(input longint s);
    return (s >= 0) ? (s >>> 8) : -((-s) >>> 8);
  endfunction

  // Apply one transaction to the predicted map; return 1 with the window result for a query.
  function automatic bit predict_shade(input pcf_item_t it, output pcf_result_t res);
    longint px, py, sx, sy, wlim, hlim, lit;
    int unsigned hits, seen;
    res  = '0;
    px   = longint'($signed(it.pos_x));
    py   = longint'($signed(it.pos_y));
    hits = 0;
    seen = 0;
    if (it.mode == MODE_WRITE) begin
      if (px >= 0 && px < MAP_W && py >= 0 && py < MAP_H) begin
        depth_map[py * MAP_W + px] = it.depth;
      end
      return 1'b0;
    end
    wlim = longint'(width_used);
    hlim = longint'(height_used);
    if (wlim > MAP_W) wlim = MAP_W;
    if (hlim > MAP_H) hlim = MAP_H;
    // Bias sum is formed wide so it never wraps.
    lit = longint'($signed(it.depth)) + longint'(bias_used);
    for (int dx = -2; dx < 2; dx++) begin
      sx = q8_trunc(px + dx * 256);
      if (sx >= 0 && sx < wlim) begin
        for (int dy = -2; dy < 2; dy++) begin
          sy = q8_trunc(py + dy * 256);
          if (sy >= 0 && sy < hlim) begin
            seen++;
            if (lit < longint'($signed(depth_map[sy * MAP_W + sx]))) hits++;
          end
        end
      end
    end
    res.shadowed   = CNT_W'(hits);
    res.valid      = CNT_W'(seen);
    res.factor     = (seen != 0) ? FACTOR_W'((hits * 256) / seen) : '0;
    res.no_samples = (seen == 0);
    return 1'b1;
  endfunction

  function automatic dir_row_t row_item(input pcf_mode_e m, input int x, input int y,
                                        input logic [DEPTH_W-1:0] d);
    dir_row_t r;
    r = '0;
    r.item.mode  = m;
    r.item.pos_x = POS_W'(x);
    r.item.pos_y = POS_W'(y);
    r.item.depth = d;
    return r;
  endfunction

  function automatic dir_row_t row_seen(input int x, input int y, input logic [DEPTH_W-1:0] d,
                                        input int s, input int v, input int f, input int n);
    dir_row_t r;
    r = row_item(MODE_QUERY, x, y, d);
    r.typed = 1'b1;
    r.want  = '{shadowed: CNT_W'(s), valid: CNT_W'(v), factor: FACTOR_W'(f),
                no_samples: n[0]};
    return r;
  endfunction

  function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [BIAS_W-1:0] data);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  // Present one transaction and hold start until the block is no longer busy and so takes it.
  task automatic issue(input pcf_item_t it, input bit typed, input pcf_result_t typed_res);
    pcf_result_t res;
    start_i <= 1'b1;
    mode_i  <= it.mode;
    pos_x_i <= it.pos_x;
    pos_y_i <= it.pos_y;
    depth_i <= it.depth;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (predict_shade(it, res)) begin
      queries_sent++;
      if (typed) res = typed_res;
      shade_expect_q = {shade_expect_q, res};
    end else begin
      writes_sent++;
    end
  endtask

  // Drain outstanding results and let the block go idle before a register write.
  task automatic settle();
    start_i <= 1'b0;
    while (shade_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BIAS_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_MAP_WIDTH:  width_used  = data[USED_W-1:0];
      REG_MAP_HEIGHT: height_used = data[USED_W-1:0];
      REG_DEPTH_BIAS: bias_used   = data;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int pick_center(input int lim);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 255;
      2:       return (lim > 0) ? ((lim > 256) ? 255 : lim - 1) : 0;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  always @(posedge clk_i) begin
    pcf_result_t want;
    if (result_valid_o) begin
      if (shade_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("MISMATCH: result with none pending: s=%0d v=%0d f=%0d n=%0d",
                   shadowed_count_o, valid_count_o, shadow_factor_o, no_samples_o);
        end
      end else begin
        want = shade_expect_q.pop_front();
        results_checked++;
        if (want.no_samples) empty_windows++;
        if (want.valid != 0 && want.shadowed == want.valid) full_shadow++;
        if (shadowed_count_o !== want.shadowed || valid_count_o !== want.valid ||
            shadow_factor_o !== want.factor || no_samples_o !== want.no_samples) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("MISMATCH @%0t: exp s=%0d v=%0d f=%0d n=%0d, got s=%0d v=%0d f=%0d n=%0d",
                     $realtime, want.shadowed, want.valid, want.factor, want.no_samples,
                     shadowed_count_o, valid_count_o, shadow_factor_o, no_samples_o);
          end
        end
      end
    end
  end

  // Count cycles with no transaction and no result; the clearing sweep fits well inside.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("TIMEOUT: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_pcf_shadow_map_test failed");
        $finish;
      end
    end
  end

  initial begin
    pcf_item_t          it;
    pcf_result_t        none;
    int                 cx, cy, lim, gap, burst, pick;
    bit                 no_gaps;
    logic [USED_W-1:0]  w, h;
    logic [BIAS_W-1:0]  b;
    logic [DEPTH_W-1:0] base;

    none = '0;
    foreach (depth_map[i]) depth_map[i] = DEPTH_FLOOR;
    width_used  = MAP_USED_RST;
    height_used = MAP_USED_RST;
    bias_used   = BIAS_RST;

    dir_rows = '{
      row_seen(0, 0, 32'd0, 0, 4, 0, 0),
      row_seen(POS_MIN, POS_MIN, 32'd0, 0, 0, 0, 1),
      row_seen(POS_MAX, POS_MAX, 32'd0, 0, 0, 0, 1),
      row_seen(128, 128, 32'd0, 0, 9, 0, 0),
      row_seen(25600, 25600, DEPTH_FLOOR, 0, 16, 0, 0),
      row_item(MODE_WRITE, 0, 0, DEPTH_MAX),
      row_item(MODE_WRITE, 1, 0, DEPTH_MAX),
      row_item(MODE_WRITE, 0, 1, DEPTH_MAX),
      row_item(MODE_WRITE, 1, 1, DEPTH_MAX),
      row_seen(0, 0, 32'd0, 4, 4, 256, 0),
      row_seen(0, 0, DEPTH_MAX, 0, 4, 0, 0),
      row_seen(0, 0, 32'h7FFF_FEB6, 4, 4, 256, 0),
      row_item(MODE_WRITE, 256, 3, DEPTH_MAX),
      row_item(MODE_WRITE, 0, -1, DEPTH_MAX),
      row_seen(0, 1024, 32'd0, 0, 8, 0, 0),
      row_seen(0, 65280, 32'd0, 0, 6, 0, 0),
      row_item(MODE_WRITE, 255, 255, DEPTH_MAX),
      row_seen(65535, 65535, 32'd0, 1, 9, 28, 0),
      row_cfg(REG_MAP_WIDTH, 16'd1),
      row_cfg(REG_MAP_HEIGHT, 16'd1),
      row_seen(0, 0, 32'd0, 1, 1, 256, 0),
      row_cfg(REG_MAP_WIDTH, 16'd0),
      row_seen(0, 0, 32'd0, 0, 0, 0, 1),
      row_cfg(REG_MAP_WIDTH, 16'd511),
      row_cfg(REG_MAP_HEIGHT, 16'd300),
      row_seen(65535, 65535, 32'd0, 1, 9, 28, 0),
      row_cfg(REG_DEPTH_BIAS, 16'hFFFF),
      row_seen(0, 0, 32'h7FFE_FFFF, 4, 4, 256, 0),
      row_cfg(REG_DEPTH_BIAS, 16'd0),
      row_cfg(REG_UNUSED, 16'd0),
      row_seen(0, 0, 32'd0, 4, 4, 256, 0),
      row_item(MODE_WRITE, 2, 0, -32'sd100),
      row_item(MODE_WRITE, 0, 2, 32'sd50),
      row_item(MODE_QUERY, 320, 320, -32'sd200)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        cfg_write(dir_rows[i].idx, dir_rows[i].data);
        settings_applied++;
      end else begin
        issue(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin w = 9'd256; h = 9'd256; b = BIAS_RST; end
        1: begin w = 9'd1; h = USED_W'($urandom_range(1, 256)); b = '0; end
        2: begin w = 9'd511; h = USED_W'($urandom_range(2, 8)); b = 16'hFFFF; end
        3: begin
          w = USED_W'($urandom_range(0, 511));
          h = USED_W'($urandom_range(0, 511));
          b = BIAS_W'($urandom);
        end
        4: begin
          w = USED_W'($urandom_range(200, 300));
          h = USED_W'($urandom_range(200, 300));
          b = BIAS_W'($urandom);
        end
        default: begin
          w = USED_W'($urandom_range(1, 16));
          h = USED_W'($urandom_range(1, 16));
          b = BIAS_W'($urandom_range(0, 2000));
        end
      endcase
      settle();
      // Junk in the upper data bits must be dropped by the 9-bit size registers.
      cfg_write(REG_MAP_WIDTH, {7'($urandom), w});
      cfg_write(REG_MAP_HEIGHT, {7'($urandom), h});
      cfg_write(REG_DEPTH_BIAS, b);
      settings_applied++;

      lim     = (w < h) ? int'(w) : int'(h);
      cx      = pick_center(lim);
      cy      = pick_center(lim);
      base    = DEPTH_W'($urandom);
      no_gaps = (ph == 2);
      burst   = 0;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (!no_gaps && burst == 0) begin
          gap = $urandom_range(1, 40);
          start_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
          burst = $urandom_range(1, 20);
        end
        if (burst > 0) burst--;
        if (n % 40 == 39) begin
          cx = pick_center(lim);
          cy = pick_center(lim);
        end

        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          // Noise: any value of any field.
          it.mode  = pcf_mode_e'($urandom_range(0, 1));
          it.pos_x = POS_W'($urandom);
          it.pos_y = POS_W'($urandom);
          it.depth = DEPTH_W'($urandom);
        end else if (pick < 50) begin
          it.mode  = MODE_WRITE;
          it.pos_x = POS_W'(cx + int'($urandom_range(0, 7)) - 3);
          it.pos_y = POS_W'(cy + int'($urandom_range(0, 7)) - 3);
          it.depth = ($urandom_range(0, 9) == 0) ? DEPTH_W'($urandom)
                   : base + DEPTH_W'(int'($urandom_range(0, 140000)) - 70000);
        end else begin
          it.mode  = MODE_QUERY;
          it.pos_x = POS_W'((cx + int'($urandom_range(0, 7)) - 3) * 256 +
                            int'($urandom_range(0, 255)));
          it.pos_y = POS_W'((cy + int'($urandom_range(0, 7)) - 3) * 256 +
                            int'($urandom_range(0, 255)));
          case ($urandom_range(0, 19))
            0:       it.depth = DEPTH_MAX;
            1:       it.depth = DEPTH_FLOOR;
            default: it.depth = base + DEPTH_W'(int'($urandom_range(0, 140000)) - 70000);
          endcase
        end
        issue(it, 1'b0, none);
      end
    end

    start_i <= 1'b0;
    while (shade_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d map writes and %0d window queries over %0d register settings.",
             writes_sent, queries_sent, settings_applied);
    $display("Checked %0d results: %0d with no samples, %0d fully shadowed; %0d mismatches.",
             results_checked, empty_windows, full_shadow, mismatches);
    if (mismatches == 0 && shade_expect_q.size() == 0) begin
      $display("tb_pcf_shadow_map_test passed");
    end else begin
      $display("tb_pcf_shadow_map_test failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/pcfsm_pkg.sv
src/pcfsm_div.sv
src/pcf_shadow_map_test.sv
dv/tb_pcf_shadow_map_test.sv
